FILE: src/tgr_pkg.sv
`timescale 1ns / 1ps

package tgr_pkg;

  localparam int GlyphCols    = 5;
  localparam int GlyphRows    = 7;
  localparam int GlyphAdvance = 6;
  localparam int PutSteps     = 2 * GlyphCols;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_PUT    = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PUT,
    ST_READ
  } state_e;

  typedef logic [3:0] step_t;
  typedef logic [0:GlyphCols-1][7:0] glyph_t;

  function automatic glyph_t glyph_rom(input logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    if (code >= 8'h61 && code <= 8'h7A) begin
      c = code - 8'h20;
    end
    case (c)
      8'h20: g = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      8'h2E: g = '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      8'h3A: g = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      8'h2D: g = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      8'h2F: g = '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
      8'h25: g = '{8'h62, 8'h64, 8'h08, 8'h13, 8'h23};
      8'h30: g = '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'h31: g = '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32: g = '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33: g = '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34: g = '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35: g = '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36: g = '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37: g = '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38: g = '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: g = '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      8'h41: g = '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      8'h42: g = '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h43: g = '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      8'h44: g = '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      8'h45: g = '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      8'h46: g = '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      8'h47: g = '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      8'h48: g = '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      8'h49: g = '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      8'h4A: g = '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      8'h4B: g = '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      8'h4C: g = '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      8'h4D: g = '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4E: g = '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      8'h4F: g = '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50: g = '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      8'h51: g = '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      8'h52: g = '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      8'h53: g = '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      8'h54: g = '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55: g = '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h56: g = '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h57: g = '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      8'h58: g = '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      8'h59: g = '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      8'h5A: g = '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      default: g = '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
    endcase
    return g;
  endfunction

endpackage

FILE: src/tgr_ram.sv
`timescale 1ns / 1ps

module tgr_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/text_glyph_rasterizer_top.sv
`timescale 1ns / 1ps

// Channel  | Ports                                              | Transfer when
// ---------+----------------------------------------------------+--------------------
// command  | kind_i pos_x_i pos_y_i char_code_i read_address_i | start & !busy
// result   | read_data_o                                        | read_valid_o
//
// Set cursor: updates the cursor without leaving idle. Read: the registered
// store byte is strobed as the result in the read state. Put: ten reads of
// the frame store port (five columns, two pages each), with the write-back of
// each step overlapped on the next read; a put too far right is dropped.
// Clear: one store byte written per cycle.
// After reset the same clearing pass runs, with busy high.
// Results cannot be stalled; busy holds off commands only.

module text_glyph_rasterizer_top #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int STORE_BYTES    = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [7:0] char_code_i,
  input  logic [9:0] read_address_i,
  output logic [7:0] read_data_o,
  output logic       read_valid_o
);

  localparam int AddrW = $clog2(STORE_BYTES);
  localparam int IdxW  = 16;

  tgr_pkg::state_e state_q, state_d;
  tgr_pkg::step_t  step_q, step_d;
  tgr_pkg::glyph_t glyph_q, glyph_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [8:0]       col_q, col_d;
  logic [7:0]       row_q, row_d;
  logic             oor_q, oor_d;

  logic             wr_en_q, wr_en_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]       wr_bits_q, wr_bits_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic [2:0]      col_sel;
  logic [8:0]      xpos;
  logic [5:0]      page;
  logic [15:0]     shifted;
  logic [7:0]      bits_raw, row_mask;
  logic [IdxW-1:0] idx;
  logic            step_active;

  // put step: column step[3:1], page half step[0]
  always_comb begin
    col_sel     = step_q[3:1];
    xpos        = col_q + 9'(col_sel);
    page        = 6'(row_q[7:3]) + 6'(step_q[0]);
    shifted     = 16'(glyph_q[col_sel][tgr_pkg::GlyphRows-1:0]) << row_q[2:0];
    bits_raw    = step_q[0] ? shifted[15:8] : shifted[7:0];
    for (int b = 0; b < 8; b++) begin
      row_mask[b] = 10'({page, 3'(b)}) < 10'(DISPLAY_HEIGHT);
    end
    idx         = IdxW'(page) * IdxW'(DISPLAY_WIDTH) + IdxW'(xpos);
    step_active = (state_q == tgr_pkg::ST_PUT) && (step_q < tgr_pkg::step_t'(tgr_pkg::PutSteps));
    wr_bits_d   = bits_raw & row_mask;
    wr_en_d     = step_active && (|wr_bits_d) && (idx < IdxW'(STORE_BYTES));
    wr_addr_d   = idx[AddrW-1:0];
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    glyph_d = glyph_q;
    clr_d   = clr_q;
    col_d   = col_q;
    row_d   = row_q;
    oor_d   = oor_q;
    unique case (state_q)
      tgr_pkg::ST_IDLE: begin
        if (start) begin
          unique case (tgr_pkg::kind_e'(kind_i))
            tgr_pkg::KIND_CLEAR: begin
              clr_d   = '0;
              state_d = tgr_pkg::ST_CLEAR;
            end
            tgr_pkg::KIND_CURSOR: begin
              col_d = 9'(pos_x_i);
              row_d = pos_y_i;
            end
            tgr_pkg::KIND_PUT: begin
              if (10'(col_q) < 10'(DISPLAY_WIDTH - tgr_pkg::GlyphCols)) begin
                glyph_d = tgr_pkg::glyph_rom(char_code_i);
                step_d  = '0;
                state_d = tgr_pkg::ST_PUT;
              end
            end
            tgr_pkg::KIND_READ: begin
              oor_d   = 32'(read_address_i) >= 32'(STORE_BYTES);
              state_d = tgr_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      tgr_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(STORE_BYTES - 1)) begin
          state_d = tgr_pkg::ST_IDLE;
        end
      end
      tgr_pkg::ST_PUT: begin
        step_d = step_q + 1'b1;
        if (step_q == tgr_pkg::step_t'(tgr_pkg::PutSteps)) begin
          col_d   = col_q + 9'(tgr_pkg::GlyphAdvance);
          state_d = tgr_pkg::ST_IDLE;
        end
      end
      tgr_pkg::ST_READ: begin
        state_d = tgr_pkg::ST_IDLE;
      end
      default: state_d = tgr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tgr_pkg::ST_CLEAR;
      step_q  <= '0;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      oor_q   <= 1'b0;
      wr_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      oor_q   <= oor_d;
      wr_en_q <= wr_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q   <= glyph_d;
    wr_addr_q <= wr_addr_d;
    wr_bits_q <= wr_bits_d;
  end

  // write-back of step n overlaps read of step n+1; the two never share a byte
  always_comb begin
    ram_we    = (state_q == tgr_pkg::ST_CLEAR) || wr_en_q;
    ram_waddr = (state_q == tgr_pkg::ST_CLEAR) ? clr_q : wr_addr_q;
    ram_wdata = (state_q == tgr_pkg::ST_CLEAR) ? 8'h00 : (ram_rdata | wr_bits_q);
    ram_raddr = (state_q == tgr_pkg::ST_PUT) ? wr_addr_d : AddrW'(read_address_i);
  end

  tgr_ram #(
    .Width(8),
    .Depth(STORE_BYTES)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy         = (state_q != tgr_pkg::ST_IDLE);
  assign read_valid_o = (state_q == tgr_pkg::ST_READ);
  assign read_data_o  = oor_q ? 8'h00 : ram_rdata;

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == tgr_pkg::KIND_READ) |=> read_valid_o)
    else $error("read transfer without result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |=> !read_valid_o)
    else $error("result strobed twice");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgr_pkg::ST_IDLE || state_q == tgr_pkg::ST_READ) |-> !ram_we)
    else $error("store written outside clear or put");

  a_put_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgr_pkg::ST_PUT && step_q == tgr_pkg::step_t'(tgr_pkg::PutSteps))
      |=> !busy)
    else $error("put did not complete");

endmodule
